### hw/rtl/tfr_pkg.sv
// ============================================================================
// tfr_pkg: shared types and constants for the text framebuffer
// Payload structs, action codes, panel stream bytes and the 6x8 font.
// ============================================================================
package tfr_pkg;

    typedef enum logic [1:0] {
        ACT_PUT_CHAR   = 2'd0,
        ACT_SET_CURSOR = 2'd1,
        ACT_CLEAR      = 2'd2,
        ACT_REFRESH    = 2'd3
    } action_t;

    typedef struct packed {
        action_t     action;
        logic [7:0]  char_code;
        logic [7:0]  cursor_column;
        logic [7:0]  cursor_page;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  bus_byte;
        logic        starts_transfer;
        logic        ends_transfer;
        logic        ends_frame;
    } bus_t;

    // One slot of the per-page panel stream, as seen by the top level
    typedef struct packed {
        logic [7:0]  hdr_byte;
        logic        from_store;
        logic        starts;
        logic        ends;
        logic        frame;
    } refresh_slot_t;

    localparam int         GLYPH_WIDTH    = 6;
    localparam int         DATA_START     = 11;
    localparam logic [6:0] DEV_ADDR_RESET = 7'd60;

    localparam logic [7:0] CMD_PAGE_BASE  = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW    = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH   = 8'h10;
    localparam logic [7:0] CTRL_COMMAND   = 8'h00;
    localparam logic [7:0] CTRL_DATA      = 8'h40;

    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_NINE      = 8'h39;
    localparam logic [7:0] CHAR_COLON     = 8'h3A;
    localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;

    localparam logic [5:0] GLYPH_BLANK    = 6'd0;
    localparam logic [5:0] GLYPH_DIGIT0   = 6'd1;
    localparam logic [5:0] GLYPH_LETTER_A = 6'd11;
    localparam logic [5:0] GLYPH_COLON    = 6'd37;

    function automatic logic [5:0] glyph_index(input logic [7:0] ch);
        logic [5:0] idx;
        idx = GLYPH_BLANK;
        if (ch inside {[CHAR_ZERO:CHAR_NINE]})
            idx = GLYPH_DIGIT0 + 6'(ch - CHAR_ZERO);
        else if (ch inside {[CHAR_UPPER_A:CHAR_UPPER_Z]})
            idx = GLYPH_LETTER_A + 6'(ch - CHAR_UPPER_A);
        else if (ch == CHAR_COLON)
            idx = GLYPH_COLON;
        return idx;
    endfunction

    // Six column bytes, leftmost column in the top byte
    function automatic logic [47:0] glyph_bitmap(input logic [5:0] idx);
        logic [47:0] g;
        case (idx)
            6'd1:    g = 48'h3E_51_49_45_3E_00;
            6'd2:    g = 48'h00_42_7F_40_00_00;
            6'd3:    g = 48'h42_61_51_49_46_00;
            6'd4:    g = 48'h21_41_45_4B_31_00;
            6'd5:    g = 48'h18_14_12_7F_10_00;
            6'd6:    g = 48'h27_45_45_45_39_00;
            6'd7:    g = 48'h3C_4A_49_49_30_00;
            6'd8:    g = 48'h01_71_09_05_03_00;
            6'd9:    g = 48'h36_49_49_49_36_00;
            6'd10:   g = 48'h06_49_49_29_1E_00;
            6'd11:   g = 48'h7E_09_09_09_7E_00;
            6'd12:   g = 48'h7F_49_49_49_36_00;
            6'd13:   g = 48'h3E_41_41_41_22_00;
            6'd14:   g = 48'h7F_41_41_22_1C_00;
            6'd15:   g = 48'h7F_49_49_49_41_00;
            6'd16:   g = 48'h7F_09_09_09_01_00;
            6'd17:   g = 48'h3E_41_49_49_7A_00;
            6'd18:   g = 48'h7F_08_08_08_7F_00;
            6'd19:   g = 48'h00_41_7F_41_00_00;
            6'd20:   g = 48'h20_40_41_3F_01_00;
            6'd21:   g = 48'h7F_08_14_22_41_00;
            6'd22:   g = 48'h7F_40_40_40_40_00;
            6'd23:   g = 48'h7F_02_0C_02_7F_00;
            6'd24:   g = 48'h7F_04_08_10_7F_00;
            6'd25:   g = 48'h3E_41_41_41_3E_00;
            6'd26:   g = 48'h7F_09_09_09_06_00;
            6'd27:   g = 48'h3E_41_51_21_5E_00;
            6'd28:   g = 48'h7F_09_19_29_46_00;
            6'd29:   g = 48'h46_49_49_49_31_00;
            6'd30:   g = 48'h01_01_7F_01_01_00;
            6'd31:   g = 48'h3F_40_40_40_3F_00;
            6'd32:   g = 48'h1F_20_40_20_1F_00;
            6'd33:   g = 48'h3F_40_38_40_3F_00;
            6'd34:   g = 48'h63_14_08_14_63_00;
            6'd35:   g = 48'h07_08_70_08_07_00;
            6'd36:   g = 48'h61_51_49_45_43_00;
            6'd37:   g = 48'h00_36_36_00_00_00;
            default: g = 48'h00_00_00_00_00_00;
        endcase
        return g;
    endfunction

endpackage

### hw/rtl/text_framebuffer_refresh.sv
// ============================================================================
// text_framebuffer_refresh: text-mode monochrome framebuffer with panel stream
// Draws 6x8 glyphs into a byte-wide pixel store and serves the panel refresh
// stream one bus byte per refresh command.
// ============================================================================
// Timing: one command transaction at a time. Set cursor and space update the
// cursor registers directly; a drawn character registers the offset product,
// then checks the bound, then, if the glyph fits, makes six single-byte writes
// through the store's one write port; a refresh command passes through the
// registered store read, then the result register, plus any time the result
// waits on bus_ready. A clear command, and reset itself, runs a zeroing sweep
// over all PANEL_WIDTH*PANEL_PAGES store entries (1024 with the default panel),
// one store entry per cycle, during which cmd_ready stays low. The device address
// register can be written at any time and takes effect on the next address byte.
module text_framebuffer_refresh #(
    parameter int PANEL_WIDTH = 128,
    parameter int PANEL_PAGES = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  tfr_pkg::cmd_t cmd,
    output logic          bus_valid,
    input  logic          bus_ready,
    output tfr_pkg::bus_t bus,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [6:0]    cfg_data
);
    import tfr_pkg::*;

    localparam int STORE_SIZE = PANEL_WIDTH * PANEL_PAGES;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    // Widest glyph offset plus one glyph, with the cursor at its extremes
    localparam int BASE_W     = $clog2(255 * PANEL_WIDTH + 256 * GLYPH_WIDTH + 1);
    localparam int CNT_W      = $clog2(GLYPH_WIDTH);

    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(STORE_SIZE - 1);
    localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(GLYPH_WIDTH - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_PREP  = 5'b00100,
        S_DRAW  = 5'b01000,
        S_READ  = 5'b10000
    } state_t;

    state_t              state_reg,   state_next;
    logic [6:0]          dev_addr_reg;
    logic [7:0]          col_reg,     col_next;
    logic [7:0]          row_reg,     row_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0]   wr_addr_reg, wr_addr_next;
    logic [CNT_W-1:0]    cnt_reg,     cnt_next;
    logic [47:0]         glyph_reg,   glyph_next;
    logic [BASE_W-1:0]   row_off_reg, row_off_next;
    logic [BASE_W-1:0]   col_off_reg, col_off_next;
    logic [BASE_W-1:0]   base_sum;
    refresh_slot_t       slot,        slot_reg, slot_hold_next;
    logic                out_valid_reg, out_valid_next;
    bus_t                out_reg,     out_next;
    logic                cmd_fire;
    logic                out_free;
    logic                refresh_adv;
    logic [ADDR_W-1:0]   rd_addr;

    // Pixel store: one write port, one registered read port
    logic [7:0]          store_mem [STORE_SIZE];
    logic [7:0]          rd_data_reg;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [7:0]          mem_wdata;

    assign cmd_fire    = cmd_valid && cmd_ready;
    assign cmd_ready   = (state_reg == S_IDLE);
    assign cfg_ready   = 1'b1;
    assign bus_valid   = out_valid_reg;
    assign bus         = out_reg;
    assign out_free    = !out_valid_reg || bus_ready;
    assign refresh_adv = cmd_fire && (cmd.action == ACT_REFRESH);
    assign base_sum    = row_off_reg + col_off_reg;

    tfr_refresh #(
        .PANEL_WIDTH (PANEL_WIDTH),
        .PANEL_PAGES (PANEL_PAGES),
        .ADDR_W      (ADDR_W)
    ) u_refresh (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (refresh_adv),
        .dev_addr (dev_addr_reg),
        .slot     (slot),
        .rd_addr  (rd_addr)
    );

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        clr_addr_next  = clr_addr_reg;
        wr_addr_next   = wr_addr_reg;
        cnt_next       = cnt_reg;
        glyph_next     = glyph_reg;
        row_off_next   = row_off_reg;
        col_off_next   = col_off_reg;
        slot_hold_next = slot_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = wr_addr_reg;
        mem_wdata      = glyph_reg[47:40];

        // Drop the result once the bus side has taken it
        if (bus_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                // Zero one entry a cycle until the whole store is swept
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_LAST)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (cmd.action)
                        ACT_PUT_CHAR:
                        begin
                            if (cmd.char_code == CHAR_SPACE)
                            begin
                                // A space only advances the cursor
                                col_next = col_reg + 8'd1;
                            end
                            else
                            begin
                                // Register the two offset terms and the glyph
                                row_off_next = BASE_W'(row_reg) * BASE_W'(PANEL_WIDTH);
                                col_off_next = BASE_W'(col_reg) * BASE_W'(GLYPH_WIDTH);
                                glyph_next   = glyph_bitmap(glyph_index(cmd.char_code));
                                state_next   = S_PREP;
                            end
                        end
                        ACT_SET_CURSOR:
                        begin
                            col_next = cmd.cursor_column;
                            row_next = cmd.cursor_page;
                        end
                        ACT_CLEAR:
                        begin
                            clr_addr_next = '0;
                            state_next    = S_CLEAR;
                        end
                        default:
                        begin
                            // Refresh: hold the slot decode while the store read lands
                            slot_hold_next = slot;
                            state_next     = S_READ;
                        end
                    endcase
                end
            end
            S_PREP:
            begin
                // Drop a glyph that would run past the end of the store
                if (base_sum + BASE_W'(GLYPH_WIDTH) <= BASE_W'(STORE_SIZE))
                begin
                    wr_addr_next = base_sum[ADDR_W-1:0];
                    cnt_next     = '0;
                    col_next     = col_reg + 8'd1;
                    state_next   = S_DRAW;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DRAW:
            begin
                // Write one glyph column a cycle, leftmost first
                mem_we       = 1'b1;
                wr_addr_next = wr_addr_reg + 1'b1;
                glyph_next   = {glyph_reg[39:0], 8'h00};
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                    state_next = S_IDLE;
            end
            S_READ:
            begin
                // Advance into the result register once it is free
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_next.bus_byte        = slot_reg.from_store ? rd_data_reg
                                                                   : slot_reg.hdr_byte;
                    out_next.starts_transfer = slot_reg.starts;
                    out_next.ends_transfer   = slot_reg.ends;
                    out_next.ends_frame      = slot_reg.frame;
                    state_next               = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            dev_addr_reg  <= DEV_ADDR_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                dev_addr_reg <= cfg_data;
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        wr_addr_reg <= wr_addr_next;
        cnt_reg     <= cnt_next;
        glyph_reg   <= glyph_next;
        row_off_reg <= row_off_next;
        col_off_reg <= col_off_next;
        slot_reg    <= slot_hold_next;
        out_reg     <= out_next;
    end

    // Pixel store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_waddr] <= mem_wdata;
        if (refresh_adv)
            rd_data_reg <= store_mem[rd_addr];
    end

endmodule

### hw/rtl/tfr_refresh.sv
// ============================================================================
// tfr_refresh: panel stream sequencer
// Tracks page and byte position of the refresh stream and decodes each slot.
// ============================================================================
module tfr_refresh #(
    parameter int PANEL_WIDTH = 128,
    parameter int PANEL_PAGES = 8,
    parameter int ADDR_W      = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic [6:0]             dev_addr,
    output tfr_pkg::refresh_slot_t slot,
    output logic [ADDR_W-1:0]      rd_addr
);
    import tfr_pkg::*;

    localparam int POS_W  = $clog2(PANEL_WIDTH + DATA_START);
    localparam int PAGE_W = (PANEL_PAGES > 1) ? $clog2(PANEL_PAGES) : 1;
    localparam int COL_W  = $clog2(PANEL_WIDTH);

    // Stream positions within one page
    localparam logic [POS_W-1:0] P_ADDR_PAGE  = POS_W'(0);
    localparam logic [POS_W-1:0] P_CTRL_PAGE  = POS_W'(1);
    localparam logic [POS_W-1:0] P_CMD_PAGE   = POS_W'(2);
    localparam logic [POS_W-1:0] P_ADDR_LOW   = POS_W'(3);
    localparam logic [POS_W-1:0] P_CTRL_LOW   = POS_W'(4);
    localparam logic [POS_W-1:0] P_CMD_LOW    = POS_W'(5);
    localparam logic [POS_W-1:0] P_ADDR_HIGH  = POS_W'(6);
    localparam logic [POS_W-1:0] P_CTRL_HIGH  = POS_W'(7);
    localparam logic [POS_W-1:0] P_CMD_HIGH   = POS_W'(8);
    localparam logic [POS_W-1:0] P_ADDR_DATA  = POS_W'(9);
    localparam logic [POS_W-1:0] P_CTRL_DATA  = POS_W'(10);
    localparam logic [POS_W-1:0] P_LAST       = POS_W'(PANEL_WIDTH + DATA_START - 1);
    localparam logic [PAGE_W-1:0] PAGE_LAST   = PAGE_W'(PANEL_PAGES - 1);
    localparam logic [COL_W-1:0]  COL_LAST    = COL_W'(PANEL_WIDTH - 1);

    logic [POS_W-1:0]  pos_reg,  pos_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [COL_W-1:0]  col;
    logic [7:0]        addr_byte;

    assign addr_byte = {dev_addr, 1'b0};
    assign col       = COL_W'(pos_reg - POS_W'(DATA_START));
    assign rd_addr   = ADDR_W'(ADDR_W'(page_reg) * ADDR_W'(PANEL_WIDTH) + ADDR_W'(col));

    always_comb
    begin
        slot = '0;
        case (pos_reg)
            P_ADDR_PAGE, P_ADDR_LOW, P_ADDR_HIGH, P_ADDR_DATA:
            begin
                slot.hdr_byte = addr_byte;
                slot.starts   = 1'b1;
            end
            P_CTRL_PAGE, P_CTRL_LOW, P_CTRL_HIGH:
                slot.hdr_byte = CTRL_COMMAND;
            P_CMD_PAGE:
            begin
                slot.hdr_byte = CMD_PAGE_BASE | 8'(page_reg);
                slot.ends     = 1'b1;
            end
            P_CMD_LOW:
            begin
                slot.hdr_byte = CMD_COL_LOW;
                slot.ends     = 1'b1;
            end
            P_CMD_HIGH:
            begin
                slot.hdr_byte = CMD_COL_HIGH;
                slot.ends     = 1'b1;
            end
            P_CTRL_DATA:
                slot.hdr_byte = CTRL_DATA;
            default:
            begin
                slot.from_store = 1'b1;
                slot.ends       = (col == COL_LAST);
                slot.frame      = (col == COL_LAST) && (page_reg == PAGE_LAST);
            end
        endcase
    end

    always_comb
    begin
        pos_next  = pos_reg;
        page_next = page_reg;
        if (advance)
        begin
            if (pos_reg == P_LAST)
            begin
                pos_next  = '0;
                page_next = (page_reg == PAGE_LAST) ? '0 : page_reg + 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            page_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            page_reg <= page_next;
        end
    end

endmodule

### hw/rtl/tfr_checker.sv
// ============================================================================
// tfr_checker: port-level checks for the text framebuffer
// Watches the bus result channel for stream framing errors and the command channel for refresh spacing.
// ============================================================================
module tfr_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_ready,
    input tfr_pkg::cmd_t cmd,
    input logic          bus_valid,
    input logic          bus_ready,
    input tfr_pkg::bus_t bus
);
    import tfr_pkg::*;

    // Hold a stalled result
    a_bus_hold: assert property (@(posedge clk) disable iff (!rst_n)
        bus_valid && !bus_ready |=> bus_valid && $stable(bus))
        else $error("bus result changed while stalled");

    a_start_end: assert property (@(posedge clk) disable iff (!rst_n)
        bus_valid |-> !(bus.starts_transfer && bus.ends_transfer))
        else $error("address byte also marked as last of a transaction");

    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        bus_valid && bus.ends_frame |-> bus.ends_transfer)
        else $error("frame end without transaction end");

    a_write_dir: assert property (@(posedge clk) disable iff (!rst_n)
        bus_valid && bus.starts_transfer |-> !bus.bus_byte[0])
        else $error("address byte without write direction");

    // A refresh transaction drops cmd_ready in the cycle after it is accepted
    a_refresh_gap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd.action == ACT_REFRESH) |=> !cmd_ready)
        else $error("command accepted straight after a refresh");

endmodule

bind text_framebuffer_refresh tfr_checker u_tfr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .bus_valid (bus_valid),
    .bus_ready (bus_ready),
    .bus       (bus)
);

### test/tb_text_framebuffer_refresh.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_text_framebuffer_refresh: self-checking bench for the text framebuffer
// Drives draw, cursor, clear and refresh commands through the command channel.
// A shadow copy of the pixel store and of the panel stream counters predicts
// every bus byte. Each bus transaction is checked against the oldest
// prediction, under random stalls on both channels and a long bus hold-off.
// ============================================================================
module tb_text_framebuffer_refresh;

    import tfr_pkg::*;

    localparam int PANEL_WIDTH  = 128;
    localparam int PANEL_PAGES  = 8;
    localparam int STORE_BYTES  = PANEL_WIDTH * PANEL_PAGES;
    localparam int PAGE_STREAM  = DATA_START + PANEL_WIDTH;
    // Header slots before the data transaction: three command transactions
    localparam int CMD_SLOTS    = 9;
    // A clear runs a sweep over the whole store with no bus result to wait on
    localparam int SETTLE_CYCLES   = STORE_BYTES + 100;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_REPORTS     = 10;
    localparam int CMD_BITS        = $bits(cmd_t);

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cmd_valid = 1'b0;
    logic       cmd_ready;
    cmd_t       cmd       = '0;
    logic       bus_valid;
    logic       bus_ready = 1'b0;
    bus_t       bus;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [6:0] cfg_data  = '0;

    // Idle rates in percent, and the bus hold-off flag
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic rx_hold     = 1'b0;

    int   items_sent = 0;
    int   failures   = 0;

    // Shadow of the block's state, updated as each command transaction lands
    logic [7:0] shadow_store [STORE_BYTES];
    logic [7:0] shadow_column  = '0;
    logic [7:0] shadow_row     = '0;
    int         stream_page    = 0;
    int         stream_pos     = 0;
    logic [6:0] shadow_address = DEV_ADDR_RESET;

    // Bus bytes still owed by the block, oldest first
    bus_t expected_bus [$];

    text_framebuffer_refresh #(
        .PANEL_WIDTH (PANEL_WIDTH),
        .PANEL_PAGES (PANEL_PAGES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .bus_valid (bus_valid),
        .bus_ready (bus_ready),
        .bus       (bus),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < STORE_BYTES; i++)
        begin
            shadow_store[i] = 8'h00;
        end
    end

    // ------------------------------------------------------------------------
    // Font: six column bytes per glyph, leftmost column in the top byte
    // ------------------------------------------------------------------------
    function automatic logic [47:0] font_columns(input int slot);
        logic [47:0] g;
        case (slot)
            1:       g = 48'h3E_51_49_45_3E_00;
            2:       g = 48'h00_42_7F_40_00_00;
            3:       g = 48'h42_61_51_49_46_00;
            4:       g = 48'h21_41_45_4B_31_00;
            5:       g = 48'h18_14_12_7F_10_00;
            6:       g = 48'h27_45_45_45_39_00;
            7:       g = 48'h3C_4A_49_49_30_00;
            8:       g = 48'h01_71_09_05_03_00;
            9:       g = 48'h36_49_49_49_36_00;
            10:      g = 48'h06_49_49_29_1E_00;
            11:      g = 48'h7E_09_09_09_7E_00;
            12:      g = 48'h7F_49_49_49_36_00;
            13:      g = 48'h3E_41_41_41_22_00;
            14:      g = 48'h7F_41_41_22_1C_00;
            15:      g = 48'h7F_49_49_49_41_00;
            16:      g = 48'h7F_09_09_09_01_00;
            17:      g = 48'h3E_41_49_49_7A_00;
            18:      g = 48'h7F_08_08_08_7F_00;
            19:      g = 48'h00_41_7F_41_00_00;
            20:      g = 48'h20_40_41_3F_01_00;
            21:      g = 48'h7F_08_14_22_41_00;
            22:      g = 48'h7F_40_40_40_40_00;
            23:      g = 48'h7F_02_0C_02_7F_00;
            24:      g = 48'h7F_04_08_10_7F_00;
            25:      g = 48'h3E_41_41_41_3E_00;
            26:      g = 48'h7F_09_09_09_06_00;
            27:      g = 48'h3E_41_51_21_5E_00;
            28:      g = 48'h7F_09_19_29_46_00;
            29:      g = 48'h46_49_49_49_31_00;
            30:      g = 48'h01_01_7F_01_01_00;
            31:      g = 48'h3F_40_40_40_3F_00;
            32:      g = 48'h1F_20_40_20_1F_00;
            33:      g = 48'h3F_40_38_40_3F_00;
            34:      g = 48'h63_14_08_14_63_00;
            35:      g = 48'h07_08_70_08_07_00;
            36:      g = 48'h61_51_49_45_43_00;
            37:      g = 48'h00_36_36_00_00_00;
            default: g = 48'h00_00_00_00_00_00;
        endcase
        return g;
    endfunction

    // Digits, capitals and colon have glyphs; every other code is blank
    function automatic int glyph_slot(input logic [7:0] ch);
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
            return int'(GLYPH_DIGIT0) + int'(ch - CHAR_ZERO);
        if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z)
            return int'(GLYPH_LETTER_A) + int'(ch - CHAR_UPPER_A);
        if (ch == CHAR_COLON)
            return int'(GLYPH_COLON);
        return int'(GLYPH_BLANK);
    endfunction

    // ------------------------------------------------------------------------
    // Predictor: apply one accepted command to the shadow state and queue the
    // bus byte that a refresh command owes
    // ------------------------------------------------------------------------
    function automatic void predict_panel_command(input cmd_t c);
        int          base;
        int          column;
        logic [47:0] bits;
        bus_t        b;
        case (c.action)
            ACT_PUT_CHAR:
            begin
                if (c.char_code == CHAR_SPACE)
                begin
                    // Space moves the cursor only, wrapping at eight bits
                    shadow_column = shadow_column + 8'd1;
                end
                else
                begin
                    base = int'(shadow_row) * PANEL_WIDTH + int'(shadow_column) * GLYPH_WIDTH;
                    // Drop a glyph that would run past the end of the store
                    if (base + GLYPH_WIDTH <= STORE_BYTES)
                    begin
                        bits = font_columns(glyph_slot(c.char_code));
                        for (int i = 0; i < GLYPH_WIDTH; i++)
                        begin
                            shadow_store[base + i] = bits[47 - 8 * i -: 8];
                        end
                        shadow_column = shadow_column + 8'd1;
                    end
                end
            end
            ACT_SET_CURSOR:
            begin
                shadow_column = c.cursor_column;
                shadow_row    = c.cursor_page;
            end
            ACT_CLEAR:
            begin
                for (int i = 0; i < STORE_BYTES; i++)
                begin
                    shadow_store[i] = 8'h00;
                end
            end
            default:
            begin
                b = '0;
                if (stream_pos < CMD_SLOTS)
                begin
                    case (stream_pos % 3)
                        0:
                        begin
                            b.bus_byte        = {shadow_address, 1'b0};
                            b.starts_transfer = 1'b1;
                        end
                        1:
                        begin
                            b.bus_byte = CTRL_COMMAND;
                        end
                        default:
                        begin
                            case (stream_pos / 3)
                                0:       b.bus_byte = CMD_PAGE_BASE | 8'(stream_page % 16);
                                1:       b.bus_byte = CMD_COL_LOW;
                                default: b.bus_byte = CMD_COL_HIGH;
                            endcase
                            b.ends_transfer = 1'b1;
                        end
                    endcase
                end
                else if (stream_pos == CMD_SLOTS)
                begin
                    b.bus_byte        = {shadow_address, 1'b0};
                    b.starts_transfer = 1'b1;
                end
                else if (stream_pos == DATA_START - 1)
                begin
                    b.bus_byte = CTRL_DATA;
                end
                else
                begin
                    column     = stream_pos - DATA_START;
                    b.bus_byte = shadow_store[stream_page * PANEL_WIDTH + column];
                    if (column == PANEL_WIDTH - 1)
                    begin
                        b.ends_transfer = 1'b1;
                        b.ends_frame    = (stream_page == PANEL_PAGES - 1);
                    end
                end
                expected_bus.push_back(b);
                // Advance through the page stream, wrapping after the last page
                stream_pos++;
                if (stream_pos >= PAGE_STREAM)
                begin
                    stream_pos  = 0;
                    stream_page = (stream_page + 1) % PANEL_PAGES;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Command builders; unused fields carry random content
    // ------------------------------------------------------------------------
    function automatic cmd_t put_char_cmd(input logic [7:0] ch);
        cmd_t c;
        c               = cmd_t'(CMD_BITS'({$urandom, $urandom}));
        c.action        = ACT_PUT_CHAR;
        c.char_code     = ch;
        return c;
    endfunction

    function automatic cmd_t cursor_cmd(input logic [7:0] column, input logic [7:0] page);
        cmd_t c;
        c               = cmd_t'(CMD_BITS'({$urandom, $urandom}));
        c.action        = ACT_SET_CURSOR;
        c.cursor_column = column;
        c.cursor_page   = page;
        return c;
    endfunction

    function automatic cmd_t clear_cmd();
        cmd_t c;
        c        = cmd_t'(CMD_BITS'({$urandom, $urandom}));
        c.action = ACT_CLEAR;
        return c;
    endfunction

    function automatic cmd_t refresh_cmd();
        cmd_t c;
        c        = cmd_t'(CMD_BITS'({$urandom, $urandom}));
        c.action = ACT_REFRESH;
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: called just after a rising edge; hold valid until the block
    // takes the transaction and leave it high for a back-to-back follow-up
    // ------------------------------------------------------------------------
    task automatic send_cmd(input cmd_t c);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        predict_panel_command(c);
        items_sent++;
    endtask

    // Drop valid, wait for every owed byte, then let any clear sweep finish
    task automatic wait_until_idle();
        cmd_valid <= 1'b0;
        while (expected_bus.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_device_address(input logic [6:0] value);
        wait_until_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid      <= 1'b0;
        shadow_address  = value;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, forced low while a hold-off is in progress
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        bus_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic void log_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    // Checker: compare every bus transaction with the oldest prediction
    always @(posedge clk)
    begin
        bus_t want;
        if (rst_n && bus_valid && bus_ready)
        begin
            if (expected_bus.size() == 0)
            begin
                log_failure($sformatf("bus byte %02h with nothing expected", bus.bus_byte));
            end
            else
            begin
                want = expected_bus.pop_front();
                if (bus.bus_byte !== want.bus_byte
                    || bus.starts_transfer !== want.starts_transfer
                    || bus.ends_transfer !== want.ends_transfer
                    || bus.ends_frame !== want.ends_frame)
                begin
                    log_failure($sformatf(
                        "expected byte %02h st %b en %b fr %b, got byte %02h st %b en %b fr %b",
                        want.bus_byte, want.starts_transfer, want.ends_transfer,
                        want.ends_frame, bus.bus_byte, bus.starts_transfer,
                        bus.ends_transfer, bus.ends_frame));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // First command transaction of page 0, with the reset bus address
    task automatic test_stream_header();
        repeat (3) send_cmd(refresh_cmd());
    endtask

    // Letters, colon, a space and a code with no glyph, then the lowest digit
    task automatic test_glyph_drawing();
        send_cmd(put_char_cmd(CHAR_UPPER_A));
        send_cmd(put_char_cmd(CHAR_UPPER_Z));
        send_cmd(put_char_cmd(CHAR_COLON));
        send_cmd(put_char_cmd(CHAR_SPACE));
        send_cmd(put_char_cmd(8'hFF));
        send_cmd(put_char_cmd(CHAR_ZERO));
    endtask

    // A glyph ending on the last store byte fits; the next one is dropped
    task automatic test_store_end();
        send_cmd(cursor_cmd(8'd127, 8'd2));
        send_cmd(put_char_cmd(CHAR_NINE));
        send_cmd(put_char_cmd(CHAR_NINE));
    endtask

    // A glyph at the end of page 0 runs on into page 1
    task automatic test_page_straddle();
        send_cmd(cursor_cmd(8'd21, 8'd0));
        send_cmd(put_char_cmd(CHAR_ZERO + 8'd5));
    endtask

    // Far-off cursor: the glyph is dropped, a space still wraps the column
    task automatic test_column_wrap();
        send_cmd(cursor_cmd(8'hFF, 8'hFF));
        send_cmd(put_char_cmd(CHAR_UPPER_A));
        send_cmd(put_char_cmd(CHAR_SPACE));
    endtask

    // Clear in mid-stream, then carry on into the data transaction
    task automatic test_clear();
        send_cmd(clear_cmd());
        repeat (7) send_cmd(refresh_cmd());
    endtask

    // Hold the bus off for a long stretch while refreshes keep arriving,
    // so the block fills and stalls its command input
    task automatic test_output_backpressure();
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
            begin
                repeat (60) send_cmd(refresh_cmd());
            end
        join
    endtask

    // ------------------------------------------------------------------------
    // Random traffic: mostly text scenes (cursor, a short string, a run of
    // refreshes), with occasional clears and raw random commands as noise
    // ------------------------------------------------------------------------
    task automatic run_text_scene();
        int         n_chars;
        logic [7:0] ch;
        n_chars = $urandom_range(1, 8);
        send_cmd(cursor_cmd(8'($urandom_range(0, 21)), 8'($urandom_range(0, 7))));
        for (int i = 0; i < n_chars; i++)
        begin
            case ($urandom_range(0, 3))
                0:       ch = CHAR_ZERO + 8'($urandom_range(0, 9));
                1:       ch = CHAR_UPPER_A + 8'($urandom_range(0, 25));
                2:       ch = ($urandom_range(0, 1) != 0) ? CHAR_COLON : CHAR_SPACE;
                default: ch = 8'($urandom);
            endcase
            send_cmd(put_char_cmd(ch));
        end
        repeat ($urandom_range(10, 44)) send_cmd(refresh_cmd());
    endtask

    task automatic test_random_traffic(input logic [6:0] address, input int tx_pct,
                                       input int rx_pct, input int n_items);
        int   target;
        int   pick;
        cmd_t c;
        write_device_address(address);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target      = items_sent + n_items;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                send_cmd(clear_cmd());
            end
            else if (pick < 90)
            begin
                run_text_scene();
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    c        = cmd_t'(CMD_BITS'({$urandom, $urandom}));
                    c.action = action_t'($urandom_range(0, 3));
                    // Keep clears rare: each one costs a full store sweep
                    if (c.action == ACT_CLEAR && $urandom_range(0, 9) != 0)
                        c.action = ACT_REFRESH;
                    send_cmd(c);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_stream_header();
        test_glyph_drawing();
        test_store_end();
        test_page_straddle();
        test_column_wrap();
        test_clear();
        test_output_backpressure();

        test_random_traffic(7'h7F, 19, 76, 470);
        test_random_traffic(7'h00, 76, 19, 470);
        test_random_traffic(7'($urandom_range(1, 126)), 0, 0, 470);

        wait_until_idle();
        if (failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### text_framebuffer_refresh.f
hw/rtl/tfr_pkg.sv
hw/rtl/tfr_refresh.sv
hw/rtl/text_framebuffer_refresh.sv
hw/rtl/tfr_checker.sv
test/tb_text_framebuffer_refresh.sv
